@@ design/fvm_pkg.sv @@
// Shared types and constants of the fading voice mixer.
`timescale 1ns / 1ps
package fvm_pkg;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_START = 2'd1,
		OP_STOP  = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_START,
		S_VOL,
		S_RD1,
		S_RD2,
		S_ACC,
		S_OUT
	} state_t;

	localparam logic [15:0] VOL_ONE    = 16'h8000;
	localparam logic [16:0] POS_MAX    = 17'h1FFFF;
	localparam logic [15:0] FADE_RESET = 16'd7;

	// controller to datapath
	typedef struct packed {
		logic latch;
		logic mem_we;
		logic do_stop;
		logic do_start;
		logic idx_clr;
		logic idx_inc;
		logic clr_acc;
		logic vol_step;
		logic rd_second;
		logic mul_left;
		logic acc_left;
		logic mul_right;
		logic acc_right;
		logic load_start;
		logic load_tick;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic go;
		logic last;
		logic out_free;
	} sts_t;

endpackage

@@ design/fvm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module fvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

@@ design/fvm_datapath.sv @@
// Voice table, sample memory, multiply-accumulate and result register of the mixer.
`timescale 1ns / 1ps
module fvm_datapath import fvm_pkg::*; #(
	parameter int VOICE_COUNT  = 8,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         operation,
	input  logic [15:0]        address,
	input  logic signed [15:0] sample_value,
	input  logic [16:0]        sound_length,
	input  logic               is_stereo,
	input  logic               cfg_we,
	input  logic [15:0]        fade_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic [3:0]         voices_active,
	output logic               start_dropped
);
	localparam int AW    = $clog2(SAMPLE_WORDS);
	localparam int SW    = (AW > 18) ? AW : 18;
	localparam int IW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int CW    = $clog2(VOICE_COUNT + 1) + 1;
	localparam int ACC_W = 33 + $clog2(VOICE_COUNT + 1);

	// latched transaction
	op_t         op_q;
	logic [15:0] addr_q;
	logic [15:0] wdata_q;
	logic [16:0] len_q;
	logic        stereo_q;
	logic [15:0] fade_q;

	// voice table
	logic        active_q [VOICE_COUNT];
	logic        fading_q [VOICE_COUNT];
	logic        vstereo_q [VOICE_COUNT];
	logic [15:0] vol_q [VOICE_COUNT];
	logic [15:0] base_q [VOICE_COUNT];
	logic [16:0] pos_q [VOICE_COUNT];
	logic [16:0] vlen_q [VOICE_COUNT];

	logic [IW-1:0]            idx_q;
	logic signed [15:0]       s0_q;
	logic signed [32:0]       prod_q;
	logic signed [ACC_W-1:0]  accl_q, accr_q;

	logic [15:0]        rdata;
	logic [AW-1:0]      raddr;
	logic [SW-1:0]      rsum;
	logic [15:0]        new_vol;
	logic [16:0]        vol_up;
	logic               free_found;
	logic [IW-1:0]      free_idx;
	logic [CW-1:0]      n_act;
	logic [CW-1:0]      n_start;
	logic [17:0]        pos_next;
	logic               has_second;
	logic signed [15:0] mul_a;
	logic signed [32:0] mul_p;
	logic signed [ACC_W-1:0] rl, rr;
	logic signed [15:0] clip_l, clip_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_q <= FADE_RESET;
		end else if (cfg_we) begin
			fade_q <= fade_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_WRITE;
		end else if (cmd.latch) begin
			op_q <= op_t'(operation);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			addr_q   <= address;
			wdata_q  <= sample_value;
			len_q    <= sound_length;
			stereo_q <= is_stereo;
		end
	end

	fvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_WORDS)) u_ram (
		.clk   (clk),
		.we    (cmd.mem_we),
		.waddr (AW'(addr_q)),
		.wdata (wdata_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// current voice
	always_comb begin
		rsum   = SW'(base_q[idx_q]) + SW'(pos_q[idx_q]) + SW'(cmd.rd_second);
		raddr  = AW'(rsum);
		vol_up = 17'(vol_q[idx_q]) + 17'(fade_q);
		if (fading_q[idx_q]) begin
			new_vol = (vol_q[idx_q] > fade_q) ? vol_q[idx_q] - fade_q : 16'd0;
		end else begin
			new_vol = (vol_up > 17'(VOL_ONE)) ? VOL_ONE : vol_up[15:0];
		end
		sts.op       = op_q;
		sts.go       = active_q[idx_q] && !(fading_q[idx_q] && new_vol == 16'd0)
			&& (pos_q[idx_q] < vlen_q[idx_q]);
		sts.last     = (idx_q == IW'(VOICE_COUNT - 1));
		sts.out_free = !out_valid || !out_stall;
		has_second   = (18'(pos_q[idx_q]) + 18'd1) < 18'(vlen_q[idx_q]);
		pos_next     = 18'(pos_q[idx_q]) + (vstereo_q[idx_q] ? 18'd2 : 18'd1);
	end

	// lowest free voice and live count
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		n_act      = '0;
		for (int v = 0; v < VOICE_COUNT; v++) begin
			if (active_q[v]) begin
				n_act = n_act + CW'(1);
			end else if (!free_found) begin
				free_found = 1'b1;
				free_idx   = IW'(v);
			end
		end
		n_start = n_act + CW'(free_found);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			for (int v = 0; v < VOICE_COUNT; v++) begin
				active_q[v]  <= 1'b0;
				fading_q[v]  <= 1'b0;
				vstereo_q[v] <= 1'b0;
				vol_q[v]     <= '0;
				base_q[v]    <= '0;
				pos_q[v]     <= '0;
				vlen_q[v]    <= '0;
			end
		end else begin
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.do_stop || cmd.do_start) begin
				for (int v = 0; v < VOICE_COUNT; v++) begin
					if (active_q[v]) begin
						fading_q[v] <= 1'b1;
					end
				end
			end
			if (cmd.do_start && free_found) begin
				active_q[free_idx]  <= 1'b1;
				fading_q[free_idx]  <= 1'b0;
				vstereo_q[free_idx] <= stereo_q;
				vol_q[free_idx]     <= '0;
				base_q[free_idx]    <= addr_q;
				pos_q[free_idx]     <= '0;
				vlen_q[free_idx]    <= len_q;
			end
			if (cmd.vol_step && active_q[idx_q]) begin
				vol_q[idx_q] <= new_vol;
				if (!sts.go) begin
					active_q[idx_q] <= 1'b0;
				end
			end
			if (cmd.acc_right) begin
				pos_q[idx_q] <= (pos_next > 18'(POS_MAX)) ? POS_MAX : pos_next[16:0];
			end
		end
	end

	// shared multiplier: sample times volume
	always_comb begin
		if (cmd.mul_left) begin
			mul_a = rdata;
		end else if (vstereo_q[idx_q]) begin
			mul_a = has_second ? rdata : 16'sd0;
		end else begin
			mul_a = s0_q;
		end
		mul_p = mul_a * $signed({1'b0, vol_q[idx_q]});
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_left) begin
			s0_q <= rdata;
		end
		if (cmd.mul_left || cmd.mul_right) begin
			prod_q <= mul_p;
		end
		if (cmd.clr_acc) begin
			accl_q <= '0;
			accr_q <= '0;
		end else begin
			if (cmd.acc_left) begin
				accl_q <= accl_q + ACC_W'(prod_q);
			end
			if (cmd.acc_right) begin
				accr_q <= accr_q + ACC_W'(prod_q);
			end
		end
	end

	// round half up, then clip
	always_comb begin
		rl = (accl_q + ACC_W'(16384)) >>> 15;
		rr = (accr_q + ACC_W'(16384)) >>> 15;
		if (rl > ACC_W'(32767)) begin
			clip_l = 16'sh7FFF;
		end else if (rl < -ACC_W'(32768)) begin
			clip_l = -16'sh8000;
		end else begin
			clip_l = rl[15:0];
		end
		if (rr > ACC_W'(32767)) begin
			clip_r = 16'sh7FFF;
		end else if (rr < -ACC_W'(32768)) begin
			clip_r = -16'sh8000;
		end else begin
			clip_r = rr[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.load_start || cmd.load_tick) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			left_out      <= '0;
			right_out     <= '0;
			voices_active <= (n_start > CW'(15)) ? 4'd15 : 4'(n_start);
			start_dropped <= !free_found;
		end else if (cmd.load_tick) begin
			left_out      <= clip_l;
			right_out     <= clip_r;
			voices_active <= (n_act > CW'(15)) ? 4'd15 : 4'(n_act);
			start_dropped <= 1'b0;
		end
	end

	a_drop_silent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_dropped |-> left_out == 16'sd0 && right_out == 16'sd0)
		else $error("dropped start carries audio");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(voices_active) <= VOICE_COUNT)
		else $error("voice count beyond table size");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_start || cmd.load_tick) |-> sts.out_free)
		else $error("result loaded over a pending transaction");
endmodule

@@ design/fvm_ctrl.sv @@
// Sequencing state machine of the mixer.
`timescale 1ns / 1ps
module fvm_ctrl import fvm_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_valid) state_d = S_EXEC;
			S_EXEC: begin
				case (sts.op)
					OP_START: state_d = S_START;
					OP_TICK:  state_d = S_VOL;
					default:  state_d = S_IDLE;
				endcase
			end
			S_START: if (sts.out_free) state_d = S_IDLE;
			S_VOL: begin
				if (sts.go) state_d = S_RD1;
				else if (sts.last) state_d = S_OUT;
			end
			S_RD1:   state_d = S_RD2;
			S_RD2:   state_d = S_ACC;
			S_ACC:   state_d = sts.last ? S_OUT : S_VOL;
			S_OUT:   if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = (state_q != S_IDLE);
		case (state_q)
			S_IDLE: cmd.latch = in_valid;
			S_EXEC: begin
				cmd.mem_we  = (sts.op == OP_WRITE);
				cmd.do_stop = (sts.op == OP_STOP);
				cmd.idx_clr = 1'b1;
				cmd.clr_acc = 1'b1;
			end
			S_START: begin
				cmd.do_start   = sts.out_free;
				cmd.load_start = sts.out_free;
			end
			S_VOL: begin
				cmd.vol_step = 1'b1;
				cmd.idx_inc  = !sts.go && !sts.last;
			end
			S_RD1: begin
				cmd.mul_left  = 1'b1;
				cmd.rd_second = 1'b1;
			end
			S_RD2: begin
				cmd.acc_left  = 1'b1;
				cmd.mul_right = 1'b1;
			end
			S_ACC: begin
				cmd.acc_right = 1'b1;
				cmd.idx_inc   = !sts.last;
			end
			S_OUT:   cmd.load_tick = sts.out_free;
			default: cmd = '0;
		endcase
	end

	a_rd_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RD1 |=> state_q == S_RD2)
		else $error("second read did not follow the first");
endmodule

@@ design/fading_voice_mixer_unit.sv @@
// Top level of the fading voice mixer.
// Use: one input channel (in_valid/in_stall) carries transactions of four kinds:
// write a sample word, start a sound, stop all voices, frame tick. One output
// channel (out_valid/out_stall) returns a frame for each tick and a status
// result for each start; writes and stops return nothing. fade_step is set
// through its own write channel (cfg_valid/cfg_ready); the user must do so
// only while idle, and the block itself does not enforce this.
// A tick walks the voice table one voice at a time: a silent or freed voice
// gets only its volume step; a playing one also gets two sample memory reads
// through the single read port and its left and right products from one
// shared multiplier, after which the frame is loaded into the output register.
// Results sit in an output register: while the receiver stalls, the next
// transaction is still taken and runs until it needs that register.
// Reset clears the voice table and sets fade_step to 7; sample memory
// is not cleared and must be written before it is played.
// SAMPLE_WORDS is taken as a power of two.
`timescale 1ns / 1ps
module fading_voice_mixer_unit import fvm_pkg::*; #(
	parameter int VOICE_COUNT  = 8,
	parameter int SAMPLE_WORDS = 65536
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         operation,
	input  logic [15:0]        address,
	input  logic signed [15:0] sample_value,
	input  logic [16:0]        sound_length,
	input  logic               is_stereo,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [15:0]        fade_step,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	output logic [3:0]         voices_active,
	output logic               start_dropped
);
	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	fvm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	fvm_datapath #(
		.VOICE_COUNT  (VOICE_COUNT),
		.SAMPLE_WORDS (SAMPLE_WORDS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (operation),
		.address       (address),
		.sample_value  (sample_value),
		.sound_length  (sound_length),
		.is_stereo     (is_stereo),
		.cfg_we        (cfg_valid && cfg_ready),
		.fade_step     (fade_step),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.left_out      (left_out),
		.right_out     (right_out),
		.voices_active (voices_active),
		.start_dropped (start_dropped)
	);
endmodule
